### hdl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; included where concurrent checks are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at each rising edge, off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same check written with a next-cycle consequent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/pls_pkg.sv
// types and constants for the plda llr scorer
// no dependencies; used by the top level
package pls_pkg;

  localparam int unsigned DIV_N     = 58;  // dividend bits of the shared divider
  localparam int unsigned DIVISOR_W = 35;
  localparam int unsigned MUL_A_W   = 34;
  localparam int unsigned MUL_B_W   = 32;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned TERM_W    = 40;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [16:0] ONE_Q16   = 17'h10000;

  typedef enum logic [4:0] {
    S_IDLE,
    S_NP,
    S_NPU,
    S_DM_LD,
    S_DM,
    S_DVA_LD,
    S_DVA,
    S_SQV,
    S_DV_LD,
    S_DV,
    S_SQD,
    S_DD_LD,
    S_DD,
    S_LN_LD,
    S_LN_NORM,
    S_LN_SQ,
    S_LN_ST,
    S_LN_CV,
    S_LN_ADD,
    S_ACC
  } state_t;

endpackage

### hdl/pls_ifs.sv
// valid/ready channels of the plda llr scorer: dimension items in, scores out
// no dependencies
interface pls_item_if;
  logic        valid;
  logic        ready;
  logic [23:0] psi_value;
  logic signed [23:0] enroll_value;
  logic signed [23:0] test_value;
  logic        last_dim;
  modport source (output valid, psi_value, enroll_value, test_value, last_dim, input ready);
  modport sink (input valid, psi_value, enroll_value, test_value, last_dim, output ready);
endinterface

interface pls_score_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] llr_score;
  logic        score_saturated;
  modport source (output valid, llr_score, score_saturated, input ready);
  modport sink (input valid, llr_score, score_saturated, output ready);
endinterface

### hdl/plda_llr_scorer.sv
// plda log-likelihood ratio scorer, diagonal model, one dimension per item
// depends on pls_pkg, pls_ifs.sv and assert_macros.svh
//
// usage:
//   item channel: one dimension per item (psi, enrollment mean, test value,
//   last_dim). score channel: one Q16.16 score plus saturation flag per vector
//   pair, sent after the item flagged last_dim.
//   cfg_wr_en/cfg_wr_data write the enrollment count while the block is idle.
//   an item passes through four 58-step divisions in the shared restoring divider
//   (one quotient bit a cycle) plus two logs, each a run of normalize steps and
//   16 squarings through the shared multiplier.
//   throughput: one item at a time; item.ready is high only when idle.
//   the score sits in an output register; a stalled receiver holds it, and the
//   block keeps taking items until the next last dimension needs that register.
//   reset (rst, synchronous): enrollment count 1, accumulator and saturation
//   flag cleared, no score pending.
`include "assert_macros.svh"

module plda_llr_scorer #(
  parameter int ACC_WIDTH = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [9:0]        cfg_wr_data,
  pls_item_if.sink          item,
  pls_score_if.source       score
);

  localparam int AW = ACC_WIDTH;

  pls_pkg::state_t state, state_next;

  logic [9:0]  enroll_count;
  logic [23:0] psi;
  logic        usign;
  logic [23:0] ua;
  logic signed [23:0] v;
  logic        last;
  logic [33:0] np;
  logic [34:0] d;
  logic [24:0] w;
  logic [25:0] va;
  logic signed [24:0] m;
  logic [24:0] dabs;
  logic [pls_pkg::PROD_W-1:0] prod;
  logic signed [pls_pkg::TERM_W-1:0] term;
  logic [34:0] rem;
  logic [pls_pkg::DIV_N-1:0] quo;
  logic [pls_pkg::DIVISOR_W-1:0] divisor;
  logic [5:0]  cnt;
  logic [30:0] y;
  logic [4:0]  p;
  logic [19:0] l2;
  logic        ln_sel;
  logic signed [AW-1:0] acc;
  logic        sat_seen;

  // shared multiplier operands
  logic [pls_pkg::MUL_A_W-1:0] mul_a;
  logic [pls_pkg::MUL_B_W-1:0] mul_b;
  logic [pls_pkg::PROD_W-1:0]  mul_p;

  // shared divider step
  logic [35:0] div_trial;
  logic        div_ge;
  logic [34:0] rem_n;
  logic [pls_pkg::DIV_N-1:0] quo_n;
  logic        div_last;

  // misc datapath
  logic signed [25:0] diff;
  logic [31:0] sq_t;
  logic [20:0] ln_val;
  logic signed [AW:0] acc_sum;
  logic signed [AW-1:0] acc_new;
  logic        acc_ovf;
  logic signed [AW-1:0] half;
  logic        fits;
  logic        out_free;
  logic [57:0] div_load;

  assign mul_p = mul_a * mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      pls_pkg::S_NP: begin
        mul_a = {24'd0, enroll_count};
        mul_b = {8'd0, psi};
      end
      pls_pkg::S_NPU: begin
        mul_a = prod[33:0];
        mul_b = {8'd0, ua};
      end
      pls_pkg::S_SQV: begin
        mul_a = {10'd0, (v[23] ? 24'(-v) : 24'(v))};
        mul_b = {8'd0, (v[23] ? 24'(-v) : 24'(v))};
      end
      pls_pkg::S_SQD: begin
        mul_a = {9'd0, dabs};
        mul_b = {7'd0, dabs};
      end
      pls_pkg::S_LN_SQ: begin
        mul_a = {3'd0, y};
        mul_b = {1'b0, y};
      end
      pls_pkg::S_LN_CV: begin
        mul_a = {14'd0, l2};
        mul_b = pls_pkg::LN2_Q32;
      end
      default: ;
    endcase
  end

  assign div_trial = {rem, quo[pls_pkg::DIV_N-1]} - {1'b0, divisor};
  assign div_ge    = {rem, quo[pls_pkg::DIV_N-1]} >= {1'b0, divisor};
  assign rem_n     = div_ge ? div_trial[34:0] : {rem[33:0], quo[pls_pkg::DIV_N-1]};
  assign quo_n     = {quo[pls_pkg::DIV_N-2:0], div_ge};
  assign div_last  = (cnt == 6'(pls_pkg::DIV_N - 1));

  assign diff   = 26'(m) - 26'(v);
  assign sq_t   = prod[61:30];
  assign ln_val = 21'((prod[51:0] + 52'h8000_0000) >> 32);

  assign acc_sum = {acc[AW-1], acc} + {{(AW + 1 - pls_pkg::TERM_W){term[pls_pkg::TERM_W-1]}}, term};
  assign acc_ovf = acc_sum[AW] != acc_sum[AW-1];
  always_comb begin
    if (acc_ovf) begin
      acc_new = acc_sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      acc_new = acc_sum[AW-1:0];
    end
  end
  assign half = acc_new >>> 1;
  assign fits = (&half[AW-1:31]) || !(|half[AW-1:31]);
  assign out_free = !score.valid || score.ready;

  always_comb begin
    div_load = '0;
    unique case (state)
      pls_pkg::S_DM_LD:  div_load = prod[57:0] + 58'({1'b0, np} + 35'(pls_pkg::ONE_Q16)) / 2;
      pls_pkg::S_DVA_LD: div_load = 58'({psi, 16'd0}) + 58'(d >> 1);
      pls_pkg::S_DV_LD:  div_load = prod[57:0] + 58'(w >> 1);
      pls_pkg::S_DD_LD:  div_load = prod[57:0] + 58'(va >> 1);
      default: ;
    endcase
  end

  assign item.ready = (state == pls_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pls_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pls_pkg::S_IDLE:    if (item.valid) state_next = pls_pkg::S_NP;
      pls_pkg::S_NP:      state_next = pls_pkg::S_NPU;
      pls_pkg::S_NPU:     state_next = pls_pkg::S_DM_LD;
      pls_pkg::S_DM_LD:   state_next = pls_pkg::S_DM;
      pls_pkg::S_DM:      if (div_last) state_next = pls_pkg::S_DVA_LD;
      pls_pkg::S_DVA_LD:  state_next = pls_pkg::S_DVA;
      pls_pkg::S_DVA:     if (div_last) state_next = pls_pkg::S_SQV;
      pls_pkg::S_SQV:     state_next = pls_pkg::S_DV_LD;
      pls_pkg::S_DV_LD:   state_next = pls_pkg::S_DV;
      pls_pkg::S_DV:      if (div_last) state_next = pls_pkg::S_SQD;
      pls_pkg::S_SQD:     state_next = pls_pkg::S_DD_LD;
      pls_pkg::S_DD_LD:   state_next = pls_pkg::S_DD;
      pls_pkg::S_DD:      if (div_last) state_next = pls_pkg::S_LN_LD;
      pls_pkg::S_LN_LD:   state_next = pls_pkg::S_LN_NORM;
      pls_pkg::S_LN_NORM: if (y[30]) state_next = pls_pkg::S_LN_SQ;
      pls_pkg::S_LN_SQ:   state_next = pls_pkg::S_LN_ST;
      pls_pkg::S_LN_ST:   state_next = (cnt == 6'd0) ? pls_pkg::S_LN_CV : pls_pkg::S_LN_SQ;
      pls_pkg::S_LN_CV:   state_next = pls_pkg::S_LN_ADD;
      pls_pkg::S_LN_ADD:  state_next = ln_sel ? pls_pkg::S_ACC : pls_pkg::S_LN_LD;
      pls_pkg::S_ACC:     if (!last || out_free) state_next = pls_pkg::S_IDLE;
      default:            state_next = pls_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enroll_count <= 10'd1;
      acc <= '0;
      sat_seen <= 1'b0;
      score.valid <= 1'b0;
      ln_sel <= 1'b0;
    end else begin
      if (cfg_wr_en) enroll_count <= cfg_wr_data;
      if (score.valid && score.ready) score.valid <= 1'b0;
      if (state == pls_pkg::S_IDLE) ln_sel <= 1'b0;
      if (state == pls_pkg::S_LN_ADD) ln_sel <= 1'b1;
      if (state == pls_pkg::S_ACC) begin
        if (!last) begin
          acc <= acc_new;
          sat_seen <= sat_seen | acc_ovf;
        end else if (out_free) begin
          acc <= '0;
          sat_seen <= 1'b0;
          score.valid <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_p;
    unique case (state)
      pls_pkg::S_IDLE: begin
        psi   <= item.psi_value;
        usign <= item.enroll_value[23];
        ua    <= item.enroll_value[23] ? 24'(-item.enroll_value) : 24'(item.enroll_value);
        v     <= item.test_value;
        last  <= item.last_dim;
        w     <= 25'(pls_pkg::ONE_Q16) + 25'(item.psi_value);
      end
      pls_pkg::S_NPU: np <= prod[33:0];
      pls_pkg::S_DM_LD, pls_pkg::S_DVA_LD, pls_pkg::S_DV_LD, pls_pkg::S_DD_LD: begin
        rem <= '0;
        quo <= div_load;
        cnt <= '0;
        unique case (state)
          pls_pkg::S_DM_LD: begin
            d <= {1'b0, np} + 35'(pls_pkg::ONE_Q16);
            divisor <= {1'b0, np} + 35'(pls_pkg::ONE_Q16);
          end
          pls_pkg::S_DVA_LD: divisor <= d;
          pls_pkg::S_DV_LD: begin
            divisor <= 35'(w);
            dabs <= diff[25] ? 25'(-diff) : 25'(diff);
          end
          default: divisor <= 35'(va);
        endcase
      end
      pls_pkg::S_DM, pls_pkg::S_DVA, pls_pkg::S_DV, pls_pkg::S_DD: begin
        rem <= rem_n;
        quo <= quo_n;
        cnt <= cnt + 6'd1;
        if (div_last) begin
          unique case (state)
            pls_pkg::S_DM:  m <= usign ? -$signed({1'b0, quo_n[23:0]}) : $signed({1'b0, quo_n[23:0]});
            pls_pkg::S_DVA: va <= 26'(pls_pkg::ONE_Q16) + quo_n[25:0];
            pls_pkg::S_DV:  term <= $signed({1'b0, quo_n[pls_pkg::TERM_W-2:0]});
            default:        term <= term - $signed({1'b0, quo_n[pls_pkg::TERM_W-2:0]});
          endcase
        end
      end
      pls_pkg::S_LN_LD: begin
        y <= ln_sel ? 31'(va) : 31'(w);
        p <= 5'd30;
      end
      pls_pkg::S_LN_NORM: begin
        if (y[30]) begin
          l2  <= {4'(p - 5'd16), 16'd0};
          cnt <= 6'd15;
        end else begin
          y <= {y[29:0], 1'b0};
          p <= p - 5'd1;
        end
      end
      pls_pkg::S_LN_ST: begin
        // y stays in [1,2) as Q1.30
        if (sq_t[31]) begin
          y <= sq_t[31:1];
          l2[cnt[3:0]] <= 1'b1;
        end else begin
          y <= sq_t[30:0];
        end
        cnt <= cnt - 6'd1;
      end
      pls_pkg::S_LN_ADD: begin
        if (ln_sel) term <= term - pls_pkg::TERM_W'($signed({1'b0, ln_val}));
        else term <= term + pls_pkg::TERM_W'($signed({1'b0, ln_val}));
      end
      pls_pkg::S_ACC: begin
        if (last && out_free) begin
          score.llr_score <= fits ? half[31:0]
                           : (half[AW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
          score.score_saturated <= sat_seen | acc_ovf | !fits;
        end
      end
      default: ;
    endcase
  end

  `ASSERT_NEXT(a_accept_starts, clk, rst, item.valid && item.ready, state == pls_pkg::S_NP, "accepted item did not start work")
  `ASSERT_NEXT(a_score_clears, clk, rst, state == pls_pkg::S_ACC && last && out_free, acc == '0 && !sat_seen && score.valid, "score did not clear the sum")
  `ASSERT_CLK(a_norm_nonzero, clk, rst, state == pls_pkg::S_LN_NORM |-> y != 31'd0, "log argument is zero")

endmodule
